FILE: rtl/core/cku_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cku_pkg - shared types and constants of the cross-kernel 2x upscaler
// Field widths, register indexes, queue entry layout and the blend function.
// ----------------------------------------------------------------------------
package cku_pkg;

	localparam int PIX_W     = 8;
	localparam int QX_W      = 11;
	localparam int QY_W      = 12;
	localparam int FW_W      = 12;
	localparam int FH_W      = 13;
	localparam int CFG_IDX_W = 2;

	localparam int MIN_SIZE   = 4;
	localparam int MAX_HEIGHT = 4096;
	localparam int FW_RESET   = 640;
	localparam int FH_RESET   = 480;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	typedef struct packed {
		logic [QX_W-1:0]  x;
		logic [QY_W-1:0]  y;
		logic [PIX_W-1:0] tl;
		logic [PIX_W-1:0] tr;
		logic [PIX_W-1:0] bl;
		logic [PIX_W-1:0] br;
		logic             two;
	} quad_entry_t;

	typedef struct packed {
		logic        valid;
		quad_entry_t entry;
	} quad_slot_t;

	// floor((2*self + a + b) / 4)
	function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] self_px,
		input logic [PIX_W-1:0] a_px, input logic [PIX_W-1:0] b_px);
		logic [PIX_W+1:0] sum;
		sum = {1'b0, self_px, 1'b0} + {2'b00, a_px} + {2'b00, b_px};
		return sum[PIX_W+1:2];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cross_kernel_2x_upscaler_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cross_kernel_2x_upscaler_top - streaming 2x grey upscaler, cross kernel
// Feed one 8-bit pixel per item in raster order with push while full is low.
// Each source pixel becomes a 2x2 quad; the quad of row y-1 leaves while row
// y arrives, so row 0 gives no result, middle rows one result per item and
// the last row two (the row above, then its own all-zero margin quad).
// Results sit on the quad ports while empty is low; pop takes one.
// last_of_item marks the final quad that a pixel causes.
// frame_width (index 0) and frame_height (index 1) are written on the cfg
// channel, which is always ready; write them only while the block is idle.
// Out-of-range sizes are clamped to 4..MAX_WIDTH and 4..4096.
// Path: an accepted item is held in stage s1 while the line store read returns,
// then is written into the queue; its first quad shows once it is queued.
// Throughput: one item per cycle while full is low, set by the single line
// store access per item (one read-modify-write plus one look-ahead read); on
// the last row the result side needs two pops per item, so full then holds
// the input back. A four-entry queue lets either side stall alone.
// Reset: counters to column 0 row 0, sizes to 640x480, queue empty; the line
// store is not cleared, its stale entries only feed margin quads.
// ----------------------------------------------------------------------------
module cross_kernel_2x_upscaler_top #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [cku_pkg::PIX_W-1:0]       pixel,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic      [cku_pkg::QX_W-1:0]        quad_x,
	output logic      [cku_pkg::QY_W-1:0]        quad_y,
	output logic      [cku_pkg::PIX_W-1:0]       top_left,
	output logic      [cku_pkg::PIX_W-1:0]       top_right,
	output logic      [cku_pkg::PIX_W-1:0]       bottom_left,
	output logic      [cku_pkg::PIX_W-1:0]       bottom_right,
	output logic                                 last_of_item,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [cku_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cku_pkg::FH_W-1:0]        cfg_data
);
	import cku_pkg::*;

	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	quad_slot_t      q_push;
	quad_slot_t      q_head;
	logic            q_space;
	logic            q_deq;

	// configuration registers; writes never stall
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(FW_RESET);
			frame_height_q <= FH_W'(FH_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[FW_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// front: accept, track position, read line store, compute quad
	cku_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.pixel        (pixel),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.space        (q_space),
		.q_push       (q_push)
	);

	// decouple compute from the result side
	cku_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.deq    (q_deq),
		.head   (q_head),
		.space  (q_space)
	);

	// back: present one or two results per queued quad
	cku_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.deq          (q_deq),
		.empty        (empty),
		.pop          (pop),
		.quad_x       (quad_x),
		.quad_y       (quad_y),
		.top_left     (top_left),
		.top_right    (top_right),
		.bottom_left  (bottom_left),
		.bottom_right (bottom_right),
		.last_of_item (last_of_item)
	);

endmodule
`default_nettype wire

FILE: rtl/core/cku_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cku_ram - generic RAM, one write port and two registered read ports
// Read data is registered from the address; contents are not reset.
// ----------------------------------------------------------------------------
module cku_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
`default_nettype wire

FILE: rtl/core/cku_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cku_front - accept pixels, track position, read the line store, blend
// Stage s1 holds the item while the line store read returns; the quad is
// computed there and handed to the queue.
// ----------------------------------------------------------------------------
module cku_front #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [cku_pkg::PIX_W-1:0]   pixel,
	input  wire logic [cku_pkg::FW_W-1:0]    frame_width,
	input  wire logic [cku_pkg::FH_W-1:0]    frame_height,
	input  wire logic                        space,
	output cku_pkg::quad_slot_t              q_push
);
	import cku_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WEW = 14;
	localparam int RW  = 2 * PIX_W;
	localparam logic [WEW-1:0]  MAXW  = WEW'(MAX_WIDTH);
	localparam logic [WEW-1:0]  MINW  = WEW'(MIN_SIZE);
	localparam logic [FH_W-1:0] MINH  = FH_W'(MIN_SIZE);
	localparam logic [FH_W-1:0] MAXH  = FH_W'(MAX_HEIGHT);

	logic [CW-1:0]    col_q;
	logic [QY_W-1:0]  row_q;
	logic [WEW-1:0]   w_eff;
	logic [WEW-1:0]   x_ext;
	logic [FH_W-1:0]  h_eff;
	logic [FH_W-1:0]  y_ext;
	logic             accept;
	logic             last_row;
	logic             inner;
	logic             col_wrap;
	logic             row_wrap;

	logic             valid_s1;
	logic [CW-1:0]    x_s1;
	logic [QY_W-1:0]  y_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             inner_s1;
	logic             last_row_s1;
	logic [PIX_W-1:0] left_q;

	logic [RW-1:0]    rd_a;
	logic [RW-1:0]    rd_b;
	logic [PIX_W-1:0] self_px;
	logic [PIX_W-1:0] up_px;
	logic [PIX_W-1:0] right_px;
	logic [WEW-1:0]   x_s1_ext;

	// clamp the size registers
	always_comb begin
		w_eff = WEW'(frame_width);
		if (w_eff < MINW) begin
			w_eff = MINW;
		end
		if (w_eff > MAXW) begin
			w_eff = MAXW;
		end
		h_eff = frame_height;
		if (h_eff < MINH) begin
			h_eff = MINH;
		end
		if (h_eff > MAXH) begin
			h_eff = MAXH;
		end
	end

	assign full   = !space;
	assign accept = push && !full;
	assign x_ext  = WEW'(col_q);
	assign y_ext  = FH_W'(row_q);

	assign last_row = (y_ext == h_eff - FH_W'(1));
	assign inner    = (x_ext >= WEW'(1)) && (x_ext <= w_eff - WEW'(3))
		&& (y_ext >= FH_W'(2)) && (y_ext <= h_eff - FH_W'(2))
		&& (x_ext + WEW'(1) < MAXW);
	assign col_wrap = (x_ext + WEW'(1) >= w_eff);
	assign row_wrap = (y_ext + FH_W'(1) >= h_eff);

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + QY_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1        <= col_q;
			y_s1        <= row_q;
			pix_s1      <= pixel;
			inner_s1    <= inner;
			last_row_s1 <= last_row;
		end
		if (valid_s1) begin
			left_q <= self_px;
		end
	end

	// each entry holds {row above, row two above}; update it once read
	cku_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.we      (valid_s1),
		.waddr   (x_s1),
		.wdata   ({pix_s1, self_px}),
		.raddr_a (col_q),
		.rdata_a (rd_a),
		.raddr_b (col_q + CW'(1)),
		.rdata_b (rd_b)
	);

	assign self_px  = rd_a[RW-1:PIX_W];
	assign up_px    = rd_a[PIX_W-1:0];
	assign right_px = rd_b[RW-1:PIX_W];
	assign x_s1_ext = WEW'(x_s1);

	always_comb begin
		q_push.valid     = valid_s1 && (y_s1 != '0);
		q_push.entry.x   = x_s1_ext[QX_W-1:0];
		q_push.entry.y   = y_s1;
		q_push.entry.two = last_row_s1;
		if (inner_s1) begin
			q_push.entry.tl = blend(self_px, up_px, left_q);
			q_push.entry.tr = blend(self_px, up_px, right_px);
			q_push.entry.bl = blend(self_px, pix_s1, left_q);
			q_push.entry.br = blend(self_px, pix_s1, right_px);
		end else begin
			q_push.entry.tl = '0;
			q_push.entry.tr = '0;
			q_push.entry.bl = '0;
			q_push.entry.br = '0;
		end
	end

`ifndef SYNTHESIS
	a_first_row_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (y_s1 == '0)) |-> !q_push.valid)
		else $error("first row item produced a quad");

	a_last_row_not_first: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_row_s1) |-> q_push.valid)
		else $error("last row item produced no quad");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/cku_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cku_queue - short queue of computed quads between front and back
// Space is reported with one slot held back for the item still in s1.
// ----------------------------------------------------------------------------
module cku_queue (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cku_pkg::quad_slot_t wr,
	input  wire logic       deq,
	output cku_pkg::quad_slot_t head,
	output logic            space
);
	import cku_pkg::*;

	quad_entry_t     mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wptr_q;
	logic [Q_AW-1:0] rptr_q;
	logic [Q_AW:0]   count_q;
	logic            do_deq;

	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rptr_q];
	assign space      = (count_q <= (Q_AW+1)'(Q_DEPTH - 2));
	assign do_deq     = deq && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr.valid) begin
				wptr_q <= wptr_q + Q_AW'(1);
			end
			if (do_deq) begin
				rptr_q <= rptr_q + Q_AW'(1);
			end
			if (wr.valid && !do_deq) begin
				count_q <= count_q + (Q_AW+1)'(1);
			end else if (!wr.valid && do_deq) begin
				count_q <= count_q - (Q_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.valid) begin
			mem_q[wptr_q] <= wr.entry;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid |-> (count_q != (Q_AW+1)'(Q_DEPTH)))
		else $error("quad queue overflow");

	a_space_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!space |-> (count_q >= (Q_AW+1)'(Q_DEPTH - 1)))
		else $error("space withdrawn too early");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/cku_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cku_back - turn queued quads into results
// A last-row entry is shown twice: its own quad, then the zero quad below.
// ----------------------------------------------------------------------------
module cku_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cku_pkg::quad_slot_t       head,
	output logic                           deq,
	output logic                           empty,
	input  wire logic                      pop,
	output logic [cku_pkg::QX_W-1:0]       quad_x,
	output logic [cku_pkg::QY_W-1:0]       quad_y,
	output logic [cku_pkg::PIX_W-1:0]      top_left,
	output logic [cku_pkg::PIX_W-1:0]      top_right,
	output logic [cku_pkg::PIX_W-1:0]      bottom_left,
	output logic [cku_pkg::PIX_W-1:0]      bottom_right,
	output logic                           last_of_item
);
	import cku_pkg::*;

	logic phase_q;
	logic take;
	logic second;

	assign empty  = !head.valid;
	assign take   = pop && head.valid;
	assign second = head.entry.two && phase_q;
	assign deq    = take && (!head.entry.two || phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (take) begin
			phase_q <= head.entry.two && !phase_q;
		end
	end

	assign quad_x       = head.entry.x;
	assign quad_y       = second ? head.entry.y : head.entry.y - QY_W'(1);
	assign top_left     = second ? '0 : head.entry.tl;
	assign top_right    = second ? '0 : head.entry.tr;
	assign bottom_left  = second ? '0 : head.entry.bl;
	assign bottom_right = second ? '0 : head.entry.br;
	assign last_of_item = !head.entry.two || phase_q;

`ifndef SYNTHESIS
	a_phase_on_pair: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (head.valid && head.entry.two))
		else $error("second half shown without a last-row entry");

	a_pair_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(take && head.entry.two && !phase_q) |=> (phase_q && !$past(deq)))
		else $error("last-row entry dropped after first quad");
`endif

endmodule
`default_nettype wire

FILE: dv/cku_quad_tracker_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cku_quad_tracker_pkg - expected-quad tracker for the 2x upscaler bench
// Keeps its own copy of the size registers, both line stores and the
// column/row counters, works out the quads each accepted pixel causes and
// checks every quad that the block hands back against the oldest one owed.
// ----------------------------------------------------------------------------
package cku_quad_tracker_pkg;

	import cku_pkg::*;

	localparam int LINE_MAX = 2048;

	typedef struct packed {
		logic [QX_W-1:0]  x;
		logic [QY_W-1:0]  y;
		logic [PIX_W-1:0] tl;
		logic [PIX_W-1:0] tr;
		logic [PIX_W-1:0] bl;
		logic [PIX_W-1:0] br;
		logic             last;
	} upscaled_quad_t;

	class quad_tracker;

		logic [FW_W-1:0]  width_reg;
		logic [FH_W-1:0]  height_reg;
		// row y-1 and row y-2 as seen from the incoming row
		logic [PIX_W-1:0] line_above [LINE_MAX];
		logic [PIX_W-1:0] line_two_up [LINE_MAX];
		int unsigned      col;
		int unsigned      row;
		upscaled_quad_t   pending_quads[$];
		int               mismatches;

		function new();
			width_reg  = FW_W'(FW_RESET);
			height_reg = FH_W'(FH_RESET);
			col        = 0;
			row        = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [FH_W-1:0] value);
			case (idx)
			REG_FRAME_WIDTH: begin
				width_reg = value[FW_W-1:0];
			end
			REG_FRAME_HEIGHT: begin
				height_reg = value;
			end
			default: begin
			end
			endcase
		endfunction

		function int unsigned line_width();
			if (width_reg < MIN_SIZE)
				return MIN_SIZE;
			if (width_reg > LINE_MAX)
				return LINE_MAX;
			return width_reg;
		endfunction

		function int unsigned frame_rows();
			if (height_reg < MIN_SIZE)
				return MIN_SIZE;
			if (height_reg > MAX_HEIGHT)
				return MAX_HEIGHT;
			return height_reg;
		endfunction

		// quarter of (twice the center plus both neighbors), rounded down
		function logic [PIX_W-1:0] cross_mix(logic [PIX_W-1:0] center,
			logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
			int unsigned total;
			total = 2 * center + a + b;
			return total[PIX_W+1:2];
		endfunction

		function void take_pixel(logic [PIX_W-1:0] value);
			int unsigned    w;
			int unsigned    h;
			int unsigned    x;
			int unsigned    y;
			int unsigned    qy;
			logic           bottom_row;
			logic [PIX_W-1:0] center;
			logic [PIX_W-1:0] left_px;
			logic [PIX_W-1:0] right_px;
			logic [PIX_W-1:0] up_px;
			upscaled_quad_t q;
			w = line_width();
			h = frame_rows();
			x = col;
			y = row;
			bottom_row = (y == h - 1);
			if (y >= 1) begin
				qy = y - 1;
				q = '0;
				q.x = x[QX_W-1:0];
				q.y = qy[QY_W-1:0];
				q.last = !bottom_row;
				if (x >= 1 && x <= w - 3 && qy >= 1 && qy <= h - 3 && x + 1 < LINE_MAX) begin
					// entry x-1 of the upper line was already moved up this row
					center   = line_above[x];
					left_px  = line_two_up[x-1];
					right_px = line_above[x+1];
					up_px    = line_two_up[x];
					q.tl = cross_mix(center, up_px, left_px);
					q.tr = cross_mix(center, up_px, right_px);
					q.bl = cross_mix(center, value, left_px);
					q.br = cross_mix(center, value, right_px);
				end
				pending_quads.push_back(q);
			end
			if (bottom_row) begin
				q = '0;
				q.x = x[QX_W-1:0];
				q.y = y[QY_W-1:0];
				q.last = 1'b1;
				pending_quads.push_back(q);
			end
			if (x < LINE_MAX) begin
				line_two_up[x] = line_above[x];
				line_above[x]  = value;
			end
			if (x + 1 >= w) begin
				col = 0;
				row = (y + 1 >= h) ? 0 : y + 1;
			end else begin
				col = x + 1;
			end
		endfunction

		function void compare_field(string field, logic [15:0] want, logic [15:0] seen);
			if (seen !== want) begin
				mismatches++;
				$error("%s: expected %0d, actual %0d", field, want, seen);
			end
		endfunction

		function void match_quad(upscaled_quad_t seen);
			upscaled_quad_t want;
			if (pending_quads.size() == 0) begin
				mismatches++;
				$error("quad with none owed: quad_x %0d quad_y %0d", seen.x, seen.y);
				return;
			end
			want = pending_quads.pop_front();
			compare_field("quad_x", want.x, seen.x);
			compare_field("quad_y", want.y, seen.y);
			compare_field("top_left", want.tl, seen.tl);
			compare_field("top_right", want.tr, seen.tr);
			compare_field("bottom_left", want.bl, seen.bl);
			compare_field("bottom_right", want.br, seen.br);
			compare_field("last_of_item", want.last, seen.last);
		endfunction

	endclass

endpackage

FILE: dv/tb_cross_kernel_2x_upscaler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cross_kernel_2x_upscaler_top - bench for the cross-kernel 2x upscaler
// Streams whole frames of grey pixels at many small sizes (some below the
// clamp, some with a stray upper width bit) plus frames resized part way
// through, with random gaps on the pixel side and random stalls on the quad
// side. A tracker predicts every quad and checks each one the block
// returns, field by field.
// ----------------------------------------------------------------------------
module tb_cross_kernel_2x_upscaler_top;

	import cku_pkg::*;
	import cku_quad_tracker_pkg::*;

	// index with no register behind it; writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	// cycles to let a pixel that owes no quad clear the pipeline
	localparam int DRAIN_GAP   = 8;
	localparam int RUN_LIMIT_NS = 4_000_000;

	typedef enum int {FILL_NOISE, FILL_WHITE, FILL_CHECKER} fill_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [PIX_W-1:0]  pixel = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [QX_W-1:0]   quad_x;
	logic [QY_W-1:0]   quad_y;
	logic [PIX_W-1:0]  top_left;
	logic [PIX_W-1:0]  top_right;
	logic [PIX_W-1:0]  bottom_left;
	logic [PIX_W-1:0]  bottom_right;
	logic              last_of_item;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [FH_W-1:0]   cfg_data = '0;

	quad_tracker board = new();

	int send_idle_pct = 0;
	int take_idle_pct = 0;
	int fed_items = 0;

	cross_kernel_2x_upscaler_top #(
		.MAX_WIDTH(LINE_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.pixel        (pixel),
		.empty        (empty),
		.pop          (pop),
		.quad_x       (quad_x),
		.quad_y       (quad_y),
		.top_left     (top_left),
		.top_right    (top_right),
		.bottom_left  (bottom_left),
		.bottom_right (bottom_right),
		.last_of_item (last_of_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: decide pop at the falling edge, stall at the current rate.
	always @(negedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= take_idle_pct);
	end

	// Check every quad taken at a rising edge against the oldest one owed.
	always @(posedge clk) begin : take_quad
		upscaled_quad_t seen;
		if (arst_n && pop && !empty) begin
			seen = '{x: quad_x, y: quad_y, tl: top_left, tr: top_right,
				bl: bottom_left, br: bottom_right, last: last_of_item};
			board.match_quad(seen);
		end
	end

	// Pick the next pixel; checker and white frames hit the blend extremes.
	function automatic logic [PIX_W-1:0] pick_pixel(fill_t style);
		case (style)
		FILL_WHITE: begin
			return '1;
		end
		FILL_CHECKER: begin
			return ((board.col + board.row) % 2) ? '1 : '0;
		end
		default: begin
			case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(255));
			endcase
		end
		endcase
	endfunction

	// Offer one item; idle first at the sender's rate. Leave push high on
	// return so back-to-back items never drop it for a step.
	task automatic send_pixel(input logic [PIX_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push  <= 1'b1;
		pixel <= value;
		do @(posedge clk); while (full);
		board.take_pixel(value);
		fed_items++;
		@(negedge clk);
	endtask

	// Write one register; hold cfg_valid high so writes can follow directly.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FH_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, value);
		@(negedge clk);
	endtask

	// Stop pushing, wait until every owed quad is back, then let the
	// pipeline empty of pixels that owe nothing (row 0).
	task automatic settle();
		push <= 1'b0;
		do @(negedge clk); while (board.pending_quads.size() != 0);
		repeat (DRAIN_GAP) @(negedge clk);
	endtask

	task automatic resize(input logic [FH_W-1:0] w_val, input logic [FH_W-1:0] h_val);
		settle();
		write_reg(REG_FRAME_WIDTH, w_val);
		write_reg(REG_FRAME_HEIGHT, h_val);
		cfg_valid <= 1'b0;
	endtask

	// Stream pixels until the counters wrap back to column 0, row 0.
	task automatic stream_frame(input fill_t style);
		do send_pixel(pick_pixel(style)); while (board.col != 0 || board.row != 0);
	endtask

	// Start a frame, stop after at least two full rows, shrink the width
	// (never grow it, so no unwritten line entry gets read), move the height
	// either way, then run on until the counters wrap.
	task automatic reshape_mid_frame();
		int unsigned w;
		int unsigned h;
		int unsigned n;
		w = $urandom_range(6, 14);
		h = $urandom_range(6, 10);
		resize(FH_W'(w), FH_W'(h));
		n = $urandom_range(2 * w, w * h - 1);
		repeat (n) send_pixel(pick_pixel(FILL_NOISE));
		resize(FH_W'($urandom_range(2, w)), FH_W'($urandom_range(2, h + 4)));
		stream_frame(FILL_NOISE);
	endtask

	// Random small frames, some with sizes below the clamp or a stray
	// upper width bit, plus at least one mid-frame resize.
	task automatic run_phase(input int send_pct, input int take_pct, input int budget);
		int start;
		logic [FH_W-1:0] w_raw;
		logic [FH_W-1:0] h_raw;
		send_idle_pct = send_pct;
		take_idle_pct = take_pct;
		start = fed_items;
		reshape_mid_frame();
		while (fed_items - start < budget) begin
			if ($urandom_range(9) == 0) begin
				reshape_mid_frame();
			end else begin
				w_raw = ($urandom_range(9) == 0) ? FH_W'($urandom_range(0, 3))
					: FH_W'($urandom_range(4, 16));
				if ($urandom_range(7) == 0)
					w_raw[FH_W-1] = 1'b1;
				h_raw = ($urandom_range(9) == 0) ? FH_W'($urandom_range(0, 3))
					: FH_W'($urandom_range(4, 9));
				resize(w_raw, h_raw);
				stream_frame(FILL_NOISE);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 31;
		take_idle_pct = 48;

		// Directed: sizes below the clamp give a 4x4 frame; all-white then
		// checkerboard drive the one inner quad to both extremes.
		resize(13'd2, 13'd3);
		stream_frame(FILL_WHITE);
		stream_frame(FILL_CHECKER);

		// A write to an unused index must leave both sizes alone.
		settle();
		write_reg(REG_SPARE, FH_W'($urandom_range(0, 8191)));
		cfg_valid <= 1'b0;

		// Random frames under three idling regimes.
		run_phase(31, 48, 260);
		run_phase(48, 31, 260);
		run_phase(0, 0, 260);

		settle();
		if (board.mismatches == 0 && board.pending_quads.size() == 0) begin
			$display("PASS cross_kernel_2x_upscaler_top");
		end else begin
			$display("FAIL cross_kernel_2x_upscaler_top");
		end
		$finish;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		#(RUN_LIMIT_NS);
		$display("FAIL cross_kernel_2x_upscaler_top");
		$finish;
	end

endmodule
